### src/dbbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbbm_pkg
// Shared sizes, codes and types of the display buffer backlog manager.
// ----------------------------------------------------------------------------
package dbbm_pkg;

    localparam int PENDING_DEPTH   = 8;
    localparam int BACKLOG_DEPTH   = 8;
    localparam int NUM_COMPOSITORS = 4;

    localparam int ID_W       = 16;
    localparam int USERS_W    = 8;
    localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int PEND_IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int BL_CNT_W   = $clog2(BACKLOG_DEPTH + 1);
    localparam int BL_IDX_W   = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;

    localparam logic [USERS_W-1:0] USERS_MAX = {USERS_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_ACQUIRE  = 2'd1,
        ACT_RELEASE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_SCHED = 3'd0,
        KIND_ACQ   = 3'd1,
        KIND_RET   = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_NOTHING      = 3'd1,
        ERR_NOT_FOUND    = 3'd2,
        ERR_QUEUE_FULL   = 3'd3,
        ERR_BACKLOG_FULL = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        BL_NOP,
        BL_PUSH,
        BL_WRITE,
        BL_REMOVE
    } bl_op_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [USERS_W-1:0] users;
        logic               consumed;
    } bl_entry_t;

    typedef struct packed {
        bl_op_t              op;
        logic [BL_IDX_W-1:0] idx;
        bl_entry_t           entry;
    } bl_cmd_t;

endpackage
`default_nettype wire

### src/dbbm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbbm_in_if
// Request channel: schedule, acquire and release words.
// ----------------------------------------------------------------------------
interface dbbm_in_if import dbbm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ID_W-1:0]   buffer_id;
    logic [1:0]        compositor_id;

    modport source (output valid, output action, output buffer_id, output compositor_id,
                    input ready);
    modport sink   (input valid, input action, input buffer_id, input compositor_id,
                    output ready);

endinterface
`default_nettype wire

### src/dbbm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbbm_out_if
// Result channel: scheduled, acquired, returned, done and error words.
// ----------------------------------------------------------------------------
interface dbbm_out_if import dbbm_pkg::*; ();

    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [ID_W-1:0]   out_buffer_id;
    err_t              error_code;
    logic              last;

    modport source (output valid, output kind, output out_buffer_id, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_buffer_id, input error_code,
                    input last, output ready);

endinterface
`default_nettype wire

### src/display_buffer_backlog_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_buffer_backlog_manager
// Passes display buffers from a client to compositors through a pending
// FIFO and a backlog of handed-out buffers, with reference counting.
// ----------------------------------------------------------------------------
//  channel  dir  word contents
//  req      in   action, buffer_id, compositor_id
//  rsp      out  kind, out_buffer_id, error_code, last
//
//  Schedule and acquire: the word is latched on accept and the result is
//  registered from S_EXEC once rsp is free; the block then returns to idle.
//  Release walks the backlog one entry per cycle, unless a returned word
//  waits on rsp: S_SEARCH looks for the id, then S_CLEAN keeps or returns
//  each entry, followed by the done word.
//  A new word is accepted only in idle, also while the last result waits.
//  A stalled rsp holds the sequencer; no clearing pass after reset.
// ----------------------------------------------------------------------------
module display_buffer_backlog_manager import dbbm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dbbm_in_if.sink     req,
    dbbm_out_if.source  rsp
);

    localparam int MASK_W = NUM_COMPOSITORS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_CLEAN
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               act_reg;
    logic [ID_W-1:0]          bid_reg;
    logic [1:0]               comp_reg;
    logic [BL_CNT_W-1:0]      idx_reg, idx_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;
    logic [PEND_CNT_W-1:0]    pcnt_reg, pcnt_next;
    logic [ID_W-1:0]          pend_reg [PENDING_DEPTH];

    logic                     out_valid_reg;
    kind_t                    out_kind_reg, out_kind_next;
    logic [ID_W-1:0]          out_id_reg, out_id_next;
    err_t                     out_err_reg, out_err_next;
    logic                     out_last_reg, out_last_next;

    logic                     emit;
    logic                     out_free;
    logic                     pend_push;
    logic                     pend_pop;
    bl_cmd_t                  bl_cmd;
    bl_entry_t                bl_rd;
    bl_entry_t                bl_front;
    logic [BL_CNT_W-1:0]      bl_count;

    logic                     comp_ok;
    logic [MASK_W-1:0]        comp_bit;
    logic                     take;
    logic                     push;

    dbbm_backlog u_backlog
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (bl_cmd),
        .rd_idx   (idx_reg[BL_IDX_W-1:0]),
        .rd_entry (bl_rd),
        .front    (bl_front),
        .count    (bl_count)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.out_buffer_id = out_id_reg;
    assign rsp.error_code    = out_err_reg;
    assign rsp.last          = out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    assign comp_ok  = (32'(comp_reg) < NUM_COMPOSITORS);
    assign comp_bit = MASK_W'(1) << comp_reg;
    assign take     = ((mask_reg & comp_bit) != '0) || (bl_count == '0);
    assign push     = take && (pcnt_reg != '0);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        pcnt_next     = pcnt_reg;
        emit          = 1'b0;
        out_kind_next = KIND_ERR;
        out_id_next   = bid_reg;
        out_err_next  = ERR_NONE;
        out_last_next = 1'b1;
        pend_push     = 1'b0;
        pend_pop      = 1'b0;
        bl_cmd        = '{op: BL_NOP, idx: '0, entry: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (act_reg)
                    ACT_SCHEDULE:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (pcnt_reg >= PEND_CNT_W'(PENDING_DEPTH))
                            begin
                                out_err_next = ERR_QUEUE_FULL;
                            end
                            else
                            begin
                                pend_push     = 1'b1;
                                pcnt_next     = pcnt_reg + PEND_CNT_W'(1);
                                out_kind_next = KIND_SCHED;
                            end
                        end
                    end
                    ACT_ACQUIRE:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (!comp_ok || (bl_count == '0 && pcnt_reg == '0))
                            begin
                                out_err_next = ERR_NOTHING;
                            end
                            else if (push && bl_count >= BL_CNT_W'(BACKLOG_DEPTH))
                            begin
                                out_err_next = ERR_BACKLOG_FULL;
                            end
                            else if (!push && bl_front.users == USERS_MAX)
                            begin
                                out_err_next = ERR_BACKLOG_FULL;
                                out_id_next  = bl_front.id;
                            end
                            else
                            begin
                                out_kind_next = KIND_ACQ;
                                mask_next     = take ? comp_bit : (mask_reg | comp_bit);
                                if (push)
                                begin
                                    // move the oldest pending buffer to the front
                                    pend_pop         = 1'b1;
                                    pcnt_next        = pcnt_reg - PEND_CNT_W'(1);
                                    bl_cmd.op        = BL_PUSH;
                                    bl_cmd.entry     = '{id: pend_reg[0],
                                                         users: USERS_W'(1),
                                                         consumed: 1'b1};
                                    out_id_next      = pend_reg[0];
                                end
                                else
                                begin
                                    bl_cmd.op        = BL_WRITE;
                                    bl_cmd.entry     = '{id: bl_front.id,
                                                         users: bl_front.users
                                                                + USERS_W'(1),
                                                         consumed: 1'b1};
                                    out_id_next      = bl_front.id;
                                end
                            end
                        end
                    end
                    ACT_RELEASE:
                    begin
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit         = 1'b1;
                            out_err_next = ERR_NOTHING;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (idx_reg >= bl_count)
                begin
                    if (out_free)
                    begin
                        emit         = 1'b1;
                        out_err_next = ERR_NOT_FOUND;
                        state_next   = S_IDLE;
                    end
                end
                else if (bl_rd.id == bid_reg)
                begin
                    // drop one user, saturating at zero
                    bl_cmd.op    = BL_WRITE;
                    bl_cmd.idx   = idx_reg[BL_IDX_W-1:0];
                    bl_cmd.entry = '{id: bl_rd.id,
                                     users: (bl_rd.users != '0) ?
                                            bl_rd.users - USERS_W'(1) : bl_rd.users,
                                     consumed: bl_rd.consumed};
                    // keep the front back while nothing is pending
                    idx_next     = (pcnt_reg == '0) ? BL_CNT_W'(1) : '0;
                    state_next   = S_CLEAN;
                end
                else
                begin
                    idx_next = idx_reg + BL_CNT_W'(1);
                end
            end
            S_CLEAN:
            begin
                if (idx_reg >= bl_count)
                begin
                    if (out_free)
                    begin
                        emit          = 1'b1;
                        out_kind_next = KIND_DONE;
                        state_next    = S_IDLE;
                    end
                end
                else if (bl_rd.users == '0 && bl_rd.consumed)
                begin
                    if (out_free)
                    begin
                        // hand the buffer back; index stays on the next entry
                        emit          = 1'b1;
                        out_kind_next = KIND_RET;
                        out_id_next   = bl_rd.id;
                        out_last_next = 1'b0;
                        bl_cmd.op     = BL_REMOVE;
                        bl_cmd.idx    = idx_reg[BL_IDX_W-1:0];
                    end
                end
                else
                begin
                    idx_next = idx_reg + BL_CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mask_reg      <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_SCHED;
            out_id_reg    <= '0;
            out_err_reg   <= ERR_NONE;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mask_reg  <= mask_next;
            pcnt_reg  <= pcnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= out_kind_next;
                out_id_reg    <= out_id_next;
                out_err_reg   <= out_err_next;
                out_last_reg  <= out_last_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word latch and pending FIFO storage
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg  <= req.action;
            bid_reg  <= req.buffer_id;
            comp_reg <= req.compositor_id;
        end
        if (pend_push)
        begin
            pend_reg[pcnt_reg[PEND_IDX_W-1:0]] <= bid_reg;
        end
        else if (pend_pop)
        begin
            for (int j = 0; j < PENDING_DEPTH - 1; j++)
            begin
                pend_reg[j] <= pend_reg[j+1];
            end
        end
    end

endmodule
`default_nettype wire

### src/dbbm_backlog.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbbm_backlog
// Backlog entry file: front insert, indexed update, compacting removal,
// one indexed read and a fixed front read.
// ----------------------------------------------------------------------------
module dbbm_backlog import dbbm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bl_cmd_t             cmd,
    input  wire logic [BL_IDX_W-1:0] rd_idx,
    output bl_entry_t                rd_entry,
    output bl_entry_t                front,
    output logic [BL_CNT_W-1:0]      count
);

    bl_entry_t             ent_reg [BACKLOG_DEPTH];
    logic [BL_CNT_W-1:0]   count_reg;

    assign rd_entry = ent_reg[rd_idx];
    assign front    = ent_reg[0];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                BL_PUSH:   count_reg <= count_reg + BL_CNT_W'(1);
                BL_REMOVE: count_reg <= count_reg - BL_CNT_W'(1);
                default:   count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            BL_PUSH:
            begin
                // shift everything one place back, new entry at the front
                for (int j = BACKLOG_DEPTH - 1; j > 0; j--)
                begin
                    ent_reg[j] <= ent_reg[j-1];
                end
                ent_reg[0] <= cmd.entry;
            end
            BL_WRITE:
            begin
                ent_reg[cmd.idx].users    <= cmd.entry.users;
                ent_reg[cmd.idx].consumed <= cmd.entry.consumed;
            end
            BL_REMOVE:
            begin
                // close the gap left by the removed entry
                for (int j = 0; j < BACKLOG_DEPTH - 1; j++)
                begin
                    if (BL_IDX_W'(j) >= cmd.idx)
                    begin
                        ent_reg[j] <= ent_reg[j+1];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire
